FILE: src/boundary_tag_first_fit_allocator_top_macros.svh
// assertion macros for the boundary tag allocator
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// checked on every rising clock edge outside reset
`define BTFFA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// checked on every rising clock edge, reset included
`define BTFFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BTFFA_ASSERT(lbl, clk, rst, prop, msg)
`define BTFFA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/btffa_pkg.sv
package btffa_pkg;

   // payload widths
   localparam int FUNC_W = 1;
   localparam int SIZE_W = 21;
   localparam int ADDR_W = 20;
   localparam int STATUS_W = 2;

   // default heap geometry
   localparam int DEF_HEAP_BYTES = 1048576;
   localparam int DEF_MIN_BLOCK = 16;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_FREE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OOM = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DFREE = 2'd3;

endpackage

FILE: src/btffa_if.sv
interface btffa_req_if
   import btffa_pkg::*;
   ();
   logic valid;
   logic ready;
   logic [FUNC_W-1:0] func;
   logic [SIZE_W-1:0] request_size;
   logic [ADDR_W-1:0] block_addr;

   modport source (output valid, func, request_size, block_addr, input ready);
   modport sink (input valid, func, request_size, block_addr, output ready);
endinterface

interface btffa_rsp_if
   import btffa_pkg::*;
   ();
   logic valid;
   logic ready;
   logic [ADDR_W-1:0] payload_addr;
   logic [STATUS_W-1:0] status;

   modport source (output valid, payload_addr, status, input ready);
   modport sink (input valid, payload_addr, status, output ready);
endinterface

FILE: src/boundary_tag_first_fit_allocator_top.sv
// channel   | dir | handshake   | payload
// req_chan  | in  | valid/ready | func, request_size, block_addr
// rsp_chan  | out | valid/ready | payload_addr, status
//
// one transaction at a time
// allocate runs a first fit walk, which reads one block header per step
// from the heap memory, which has separate read and write ports
// reset clears control state only; heap words stay unknown until written
// a result waits in the output register; the next request is taken meanwhile
`include "boundary_tag_first_fit_allocator_top_macros.svh"

module boundary_tag_first_fit_allocator_top
   import btffa_pkg::*;
   #(
   parameter int HEAP_BYTES = DEF_HEAP_BYTES,
   parameter int MIN_BLOCK = DEF_MIN_BLOCK
   )
   (
   input logic clock,
   input logic reset,
   btffa_req_if.sink req_chan,
   btffa_rsp_if.source rsp_chan
   );

   localparam int HB_W = $clog2(HEAP_BYTES);
   localparam int MW = HB_W + 1;
   localparam int OW = ((HB_W + 1) > (SIZE_W + 1) ? (HB_W + 1) : (SIZE_W + 1)) + 1;
   localparam int WORDS = HEAP_BYTES / 8;
   localparam int IW = $clog2(WORDS);
   localparam int SMALLEST = (MIN_BLOCK + 7) / 8 * 8;

   localparam logic [OW-1:0] HEAP_O = OW'(HEAP_BYTES);
   localparam logic [OW-1:0] SM_O = OW'(SMALLEST);
   localparam logic [OW-1:0] EIGHT = OW'(8);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_INIT0 = 5'd1;
   localparam logic [4:0] S_INIT1 = 5'd2;
   localparam logic [4:0] S_INIT2 = 5'd3;
   localparam logic [4:0] S_FF_RD = 5'd4;
   localparam logic [4:0] S_FF_CHK = 5'd5;
   localparam logic [4:0] S_GROW = 5'd6;
   localparam logic [4:0] S_G_HDR = 5'd7;
   localparam logic [4:0] S_G_FTR = 5'd8;
   localparam logic [4:0] S_G_EPI = 5'd9;
   localparam logic [4:0] S_SP_HDR = 5'd10;
   localparam logic [4:0] S_SP_FTR = 5'd11;
   localparam logic [4:0] S_A_HDR = 5'd12;
   localparam logic [4:0] S_A_NXRD = 5'd13;
   localparam logic [4:0] S_A_NXCHK = 5'd14;
   localparam logic [4:0] S_F_RDH = 5'd15;
   localparam logic [4:0] S_F_CHKH = 5'd16;
   localparam logic [4:0] S_F_CHKN = 5'd17;
   localparam logic [4:0] S_F_CHKF = 5'd18;
   localparam logic [4:0] S_F_CHKP = 5'd19;
   localparam logic [4:0] S_M_HDR = 5'd20;
   localparam logic [4:0] S_M_FTR = 5'd21;
   localparam logic [4:0] S_M_AFRD = 5'd22;
   localparam logic [4:0] S_M_AFCHK = 5'd23;
   localparam logic [4:0] S_M_NXWR = 5'd24;
   localparam logic [4:0] S_RESP = 5'd25;

   // heap memory
   logic [MW-1:0] heap_mem [WORDS];
   logic [MW-1:0] rdata_ff;
   logic oor_ff;

   logic [4:0] state_ff, state_in;
   logic ready_ff, ready_in;
   logic [OW-1:0] epi_ff, epi_in;
   logic [OW-1:0] need_ff, need_in;
   logic [OW-1:0] h_ff, h_in;
   logic [OW-1:0] s_ff, s_in;
   logic pf_ff, pf_in;
   logic [OW-1:0] last_ff, last_in;
   logic [OW-1:0] lastw_ff, lastw_in;
   logic [OW-1:0] nxw_ff, nxw_in;
   logic nf_ff, nf_in;
   logic [OW-1:0] base_ff, base_in;
   logic [OW-1:0] stot_ff, stot_in;
   logic bpf_ff, bpf_in;
   logic [ADDR_W-1:0] pay_ff, pay_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_pay_ff, rsp_pay_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [OW-1:0] rd_off;
   logic [OW-1:0] wr_off;
   logic [OW-1:0] wr_val;
   logic wr_req;
   logic wr_en;
   logic [OW-1:0] rd_word;
   logic [OW-1:0] rsize;
   logic ralloc;
   logic rpf;
   logic req_fire;
   logic [OW-1:0] round_need;
   logic [OW-1:0] addr_o;

   // decoded read word; offsets beyond the heap read as zero
   assign rd_word = oor_ff ? '0 : OW'(rdata_ff);
   assign rsize = {rd_word[OW-1:3], 3'b000};
   assign ralloc = rd_word[0];
   assign rpf = rd_word[1];

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign round_need = (OW'(req_chan.request_size) + OW'(15)) & ~OW'(7);
   assign addr_o = OW'(req_chan.block_addr);
   assign wr_en = wr_req && (wr_off < HEAP_O);

   // memory port, one read and one write per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_off[IW+2:3]] <= MW'(wr_val);
      end
      rdata_ff <= heap_mem[rd_off[IW+2:3]];
      oor_ff <= (rd_off >= HEAP_O);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      epi_in = epi_ff;
      need_in = need_ff;
      h_in = h_ff;
      s_in = s_ff;
      pf_in = pf_ff;
      last_in = last_ff;
      lastw_in = lastw_ff;
      nxw_in = nxw_ff;
      nf_in = nf_ff;
      base_in = base_ff;
      stot_in = stot_ff;
      bpf_in = bpf_ff;
      pay_in = pay_ff;
      status_in = status_ff;
      rd_off = h_ff;
      wr_off = h_ff;
      wr_val = '0;
      wr_req = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               status_in = ST_OK;
               pay_in = '0;
               h_in = '0;
               last_in = '0;
               if (req_chan.func == FUNC_ALLOC) begin
                  need_in = (round_need < SM_O) ? SM_O : round_need;
                  if (req_chan.request_size == '0) begin
                     status_in = ST_NULL;
                     state_in = S_RESP;
                  end else if (!ready_ff) begin
                     state_in = S_INIT0;
                  end else begin
                     state_in = S_FF_RD;
                  end
               end else begin
                  h_in = addr_o - EIGHT;
                  if (req_chan.block_addr == '0 || !ready_ff || addr_o[2:0] != 3'b000 ||
                      addr_o < SM_O + EIGHT || addr_o - EIGHT >= epi_ff) begin
                     status_in = ST_NULL;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_F_RDH;
                  end
               end
            end
         end
         // prologue header, prologue footer, epilogue
         S_INIT0: begin
            wr_req = 1'b1;
            wr_off = '0;
            wr_val = SM_O | OW'(1);
            state_in = S_INIT1;
         end
         S_INIT1: begin
            wr_req = 1'b1;
            wr_off = SM_O - EIGHT;
            wr_val = SM_O | OW'(1);
            state_in = S_INIT2;
         end
         S_INIT2: begin
            wr_req = 1'b1;
            wr_off = SM_O;
            wr_val = OW'(1);
            epi_in = SM_O;
            ready_in = 1'b1;
            state_in = S_FF_RD;
         end
         // first fit walk
         S_FF_RD: begin
            rd_off = h_ff;
            state_in = (h_ff >= epi_ff) ? S_GROW : S_FF_CHK;
         end
         S_FF_CHK: begin
            if (!ralloc && rsize >= need_ff) begin
               s_in = rsize;
               pf_in = rpf;
               state_in = S_SP_HDR;
            end else begin
               last_in = h_ff;
               lastw_in = rd_word;
               h_in = (rsize == '0 || rsize >= epi_ff - h_ff) ? epi_ff : h_ff + rsize;
               state_in = S_FF_RD;
            end
         end
         // extend at the epilogue, merging with a free last block
         S_GROW: begin
            if (epi_ff + need_ff + EIGHT > HEAP_O) begin
               status_in = ST_OOM;
               state_in = S_RESP;
            end else begin
               if (!lastw_ff[0]) begin
                  h_in = last_ff;
                  s_in = {lastw_ff[OW-1:3], 3'b000} + need_ff;
                  pf_in = lastw_ff[1];
               end else begin
                  h_in = epi_ff;
                  s_in = need_ff;
                  pf_in = 1'b0;
               end
               state_in = S_G_HDR;
            end
         end
         S_G_HDR: begin
            wr_req = 1'b1;
            wr_off = h_ff;
            wr_val = s_ff | {{(OW-2){1'b0}}, pf_ff, 1'b0};
            state_in = S_G_FTR;
         end
         S_G_FTR: begin
            wr_req = 1'b1;
            wr_off = h_ff + s_ff - EIGHT;
            wr_val = s_ff;
            state_in = S_G_EPI;
         end
         S_G_EPI: begin
            wr_req = 1'b1;
            wr_off = epi_ff + need_ff;
            wr_val = OW'(3);
            epi_in = epi_ff + need_ff;
            state_in = S_SP_HDR;
         end
         // split off the remainder as a free block
         S_SP_HDR: begin
            if (s_ff - need_ff >= SM_O) begin
               wr_req = 1'b1;
               wr_off = h_ff + need_ff;
               wr_val = s_ff - need_ff;
               state_in = S_SP_FTR;
            end else begin
               state_in = S_A_HDR;
            end
         end
         S_SP_FTR: begin
            wr_req = 1'b1;
            wr_off = h_ff + s_ff - EIGHT;
            wr_val = s_ff - need_ff;
            s_in = need_ff;
            state_in = S_A_HDR;
         end
         S_A_HDR: begin
            wr_req = 1'b1;
            wr_off = h_ff;
            wr_val = s_ff | {{(OW-2){1'b0}}, pf_ff, 1'b1};
            pay_in = ADDR_W'(h_ff + EIGHT);
            state_in = S_A_NXRD;
         end
         // clear prev_free in the following header
         S_A_NXRD: begin
            rd_off = h_ff + s_ff;
            state_in = (h_ff + s_ff >= epi_ff) ? S_RESP : S_A_NXCHK;
         end
         S_A_NXCHK: begin
            if (rsize != '0) begin
               wr_req = 1'b1;
               wr_off = h_ff + s_ff;
               wr_val = rd_word & ~OW'(2);
            end
            state_in = S_RESP;
         end
         // free: header, next header, previous footer, previous header
         S_F_RDH: begin
            rd_off = h_ff;
            state_in = S_F_CHKH;
         end
         S_F_CHKH: begin
            rd_off = h_ff + rsize;
            s_in = rsize;
            pf_in = rpf;
            if (!ralloc) begin
               status_in = ST_DFREE;
               state_in = S_RESP;
            end else begin
               state_in = S_F_CHKN;
            end
         end
         S_F_CHKN: begin
            rd_off = h_ff - EIGHT;
            nxw_in = rd_word;
            nf_in = (h_ff + s_ff < epi_ff) && rsize != '0 && !ralloc;
            stot_in = s_ff + ((h_ff + s_ff < epi_ff && rsize != '0 && !ralloc) ? rsize : '0);
            base_in = h_ff;
            bpf_in = 1'b0;
            state_in = pf_ff ? S_F_CHKF : S_M_HDR;
         end
         S_F_CHKF: begin
            rd_off = h_ff - rsize;
            base_in = h_ff - rsize;
            state_in = S_F_CHKP;
         end
         S_F_CHKP: begin
            bpf_in = rpf;
            stot_in = stot_ff + rsize;
            state_in = S_M_HDR;
         end
         S_M_HDR: begin
            wr_req = 1'b1;
            wr_off = base_ff;
            wr_val = stot_ff | {{(OW-2){1'b0}}, bpf_ff, 1'b0};
            state_in = S_M_FTR;
         end
         S_M_FTR: begin
            wr_req = 1'b1;
            wr_off = base_ff + stot_ff - EIGHT;
            wr_val = stot_ff;
            state_in = nf_ff ? S_M_AFRD : S_M_NXWR;
         end
         // set prev_free in the block after the merged one
         S_M_AFRD: begin
            rd_off = base_ff + stot_ff;
            state_in = (base_ff + stot_ff >= epi_ff) ? S_RESP : S_M_AFCHK;
         end
         S_M_AFCHK: begin
            if (rsize != '0) begin
               wr_req = 1'b1;
               wr_off = base_ff + stot_ff;
               wr_val = rd_word | OW'(2);
            end
            state_in = S_RESP;
         end
         S_M_NXWR: begin
            wr_req = 1'b1;
            wr_off = h_ff + s_ff;
            wr_val = nxw_ff | OW'(2);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pay_in = rsp_pay_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_RESP && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_valid_in = 1'b1;
         rsp_pay_in = pay_ff;
         rsp_status_in = status_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload_addr = rsp_pay_ff;
   assign rsp_chan.status = rsp_status_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
         epi_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         epi_ff <= epi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      need_ff <= need_in;
      h_ff <= h_in;
      s_ff <= s_in;
      pf_ff <= pf_in;
      last_ff <= last_in;
      lastw_ff <= lastw_in;
      nxw_ff <= nxw_in;
      nf_ff <= nf_in;
      base_ff <= base_in;
      stot_ff <= stot_in;
      bpf_ff <= bpf_in;
      pay_ff <= pay_in;
      status_ff <= status_in;
      rsp_pay_ff <= rsp_pay_in;
      rsp_status_ff <= rsp_status_in;
   end

   // checks
   `BTFFA_ASSERT(a_ready_sticky, clock, reset, $past(ready_ff) && !$past(reset) |-> ready_ff, "heap lost ready")
   `BTFFA_ASSERT(a_epi_fits, clock, reset, ready_ff |-> (epi_ff + EIGHT <= HEAP_O), "epilogue beyond heap")
   `BTFFA_ASSERT_ALWAYS(a_no_idle_write, clock, (state_ff == S_IDLE) |-> !wr_req, "heap write while idle")

endmodule

FILE: tb/tb_top.sv
module tb_top;
   import btffa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned HEAP_SZ = DEF_HEAP_BYTES;
   localparam longint unsigned WORDS = HEAP_SZ / 8;
   localparam longint unsigned MINBLK = (DEF_MIN_BLOCK + 7) / 8 * 8;
   localparam logic [63:0] SZ_MASK = ~64'd7;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int RANDOM_ITEMS = 550;
   localparam int MAX_LIVE = 40;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] block_addr;
      logic [ADDR_W-1:0] exp_addr;
      logic [STATUS_W-1:0] exp_status;
   } heap_op_t;

   typedef struct {
      logic [ADDR_W-1:0] payload_addr;
      logic [STATUS_W-1:0] status;
   } heap_rsp_t;

   logic clock;
   logic reset;
   btffa_req_if req_chan ();
   btffa_rsp_if rsp_chan ();

   boundary_tag_first_fit_allocator_top dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   // shadow heap and allocator state
   logic [63:0] shadow_heap[longint unsigned];
   bit heap_built;
   longint unsigned epi_off;

   heap_op_t op_q[$];
   heap_rsp_t rsp_exp_q[$];
   longint unsigned live_q[$];
   longint unsigned dead_q[$];
   bit failed;
   bit stim_done;
   int cycle_cnt;
   int rsp_cnt;

   function automatic logic [63:0] hrd(longint unsigned off);
      if ((off >> 3) >= WORDS) return 64'd0;
      if (shadow_heap.exists(off >> 3)) return shadow_heap[off >> 3];
      return 64'd0;
   endfunction

   function automatic void hwr(longint unsigned off, logic [63:0] v);
      if ((off >> 3) < WORDS) shadow_heap[off >> 3] = v;
   endfunction

   function automatic longint unsigned blk_size(longint unsigned off);
      return hrd(off) & SZ_MASK;
   endfunction

   function automatic bit blk_alloc(longint unsigned off);
      return hrd(off) & 64'd1;
   endfunction

   function automatic bit blk_pf(longint unsigned off);
      return (hrd(off) >> 1) & 64'd1;
   endfunction

   function automatic void set_hdr(longint unsigned off, longint unsigned sz, bit a, bit p);
      hwr(off, (sz & SZ_MASK) | 64'(a) | (64'(p) << 1));
   endfunction

   function automatic void set_free(longint unsigned off, longint unsigned sz, bit p);
      set_hdr(off, sz, 1'b0, p);
      hwr(off + sz - 8, sz & SZ_MASK);
   endfunction

   function automatic bit past_end(longint unsigned off);
      return off >= epi_off || blk_size(off) == 0;
   endfunction

   function automatic longint unsigned next_blk(longint unsigned off);
      longint unsigned s;
      s = blk_size(off);
      if (s == 0 || s >= epi_off - off) return epi_off;
      return off + s;
   endfunction

   function automatic longint unsigned fit_search(longint unsigned need);
      longint unsigned h;
      for (h = 0; h < epi_off; h = next_blk(h))
         if (!blk_alloc(h) && blk_size(h) >= need) return h;
      return epi_off;
   endfunction

   // extend at the epilogue, absorbing a free last block
   function automatic bit extend_heap(longint unsigned need, output longint unsigned blk);
      longint unsigned old_epi, last, h, new_epi;
      old_epi = epi_off;
      last = 0;
      blk = 0;
      if (old_epi + need + 8 > HEAP_SZ) return 1'b0;
      for (h = 0; h < epi_off; h = next_blk(h)) last = h;
      new_epi = old_epi + need;
      if (!blk_alloc(last)) begin
         set_free(last, blk_size(last) + need, blk_pf(last));
         blk = last;
      end else begin
         set_free(old_epi, need, 1'b0);
         blk = old_epi;
      end
      set_hdr(new_epi, 0, 1'b1, 1'b1);
      epi_off = new_epi;
      return 1'b1;
   endfunction

   function automatic void coalesce(longint unsigned h);
      longint unsigned s, nx, p, af;
      bit pfb, nf;
      s = blk_size(h);
      nx = h + s;
      p = 0;
      pfb = blk_pf(h);
      nf = !past_end(nx) && !blk_alloc(nx);
      if (pfb) p = h - blk_size(h - 8);
      if (pfb && nf) begin
         s += blk_size(p) + blk_size(nx);
         set_free(p, s, blk_pf(p));
         af = p + s;
         if (!past_end(af)) set_hdr(af, blk_size(af), blk_alloc(af), 1'b1);
      end else if (pfb) begin
         s += blk_size(p);
         set_free(p, s, blk_pf(p));
         set_hdr(nx, blk_size(nx), blk_alloc(nx), 1'b1);
      end else if (nf) begin
         s += blk_size(nx);
         set_free(h, s, 1'b0);
         af = h + s;
         if (!past_end(af)) set_hdr(af, blk_size(af), blk_alloc(af), 1'b1);
      end else begin
         set_free(h, s, 1'b0);
         set_hdr(nx, blk_size(nx), blk_alloc(nx), 1'b1);
      end
   endfunction

   // expected response of one request, updating the shadow heap
   function automatic void alloc_predict(inout heap_op_t op);
      longint unsigned req, addr, need, h, nx, s;
      req = op.request_size;
      addr = op.block_addr;
      op.exp_addr = '0;
      op.exp_status = ST_OK;
      if (op.func == FUNC_ALLOC) begin
         if (req == 0) begin
            op.exp_status = ST_NULL;
         end else begin
            need = (req + 15) & SZ_MASK;
            if (need < MINBLK) need = MINBLK;
            if (!heap_built) begin
               set_hdr(0, MINBLK, 1'b1, 1'b0);
               hwr(MINBLK - 8, MINBLK | 1);
               set_hdr(MINBLK, 0, 1'b1, 1'b0);
               epi_off = MINBLK;
               heap_built = 1'b1;
            end
            h = fit_search(need);
            if (h >= epi_off && !extend_heap(need, h)) begin
               op.exp_status = ST_OOM;
            end else begin
               // split off a usable remainder
               s = blk_size(h);
               if (s >= need && s - need >= MINBLK) begin
                  set_free(h + need, s - need, 1'b0);
                  set_hdr(h, need, 1'b1, blk_pf(h));
               end
               set_hdr(h, blk_size(h), 1'b1, blk_pf(h));
               nx = h + blk_size(h);
               if (!past_end(nx)) set_hdr(nx, blk_size(nx), blk_alloc(nx), 1'b0);
               op.exp_addr = ADDR_W'(h + 8);
            end
         end
      end else begin
         if (addr == 0 || !heap_built || (addr & 7) != 0 || addr < MINBLK + 8 ||
             addr - 8 >= epi_off) begin
            op.exp_status = ST_NULL;
         end else if (!blk_alloc(addr - 8)) begin
            op.exp_status = ST_DFREE;
         end else begin
            coalesce(addr - 8);
         end
      end
   endfunction

   // queue one request and keep track of live and freed blocks
   task automatic push_op(logic [FUNC_W-1:0] f, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] a);
      heap_op_t op;
      int idx;
      op.func = f;
      op.request_size = sz;
      op.block_addr = a;
      alloc_predict(op);
      if (f == FUNC_ALLOC && op.exp_status == ST_OK) live_q.push_back(op.exp_addr);
      if (f == FUNC_FREE && op.exp_status == ST_OK) begin
         for (idx = 0; idx < live_q.size(); idx++)
            if (live_q[idx] == a) begin
               live_q.delete(idx);
               break;
            end
         dead_q.push_back(a);
      end
      op_q.push_back(op);
   endtask

   task automatic push_alloc(logic [SIZE_W-1:0] sz);
      push_op(FUNC_ALLOC, sz, ADDR_W'($urandom));
   endtask

   task automatic push_free(logic [ADDR_W-1:0] a);
      push_op(FUNC_FREE, SIZE_W'($urandom), a);
   endtask

   task automatic free_live_at(int idx);
      push_free(ADDR_W'(live_q[idx]));
   endtask

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // stimulus
   initial begin
      int n, sel, idx;
      longint unsigned a;
      heap_built = 1'b0;
      epi_off = 0;
      failed = 1'b0;
      stim_done = 1'b0;

      // directed: corner cases before and after the heap exists
      push_alloc(0);
      push_free(ADDR_W'(24));
      push_free(0);
      push_alloc(1);
      push_alloc(8);
      push_alloc(9);
      push_alloc(SIZE_W'(1048576));
      push_alloc(SIZE_W'(1048575));
      push_alloc('1);
      push_free(ADDR_W'(43));
      push_free(ADDR_W'(8));
      push_free(ADDR_W'(16));
      push_free(ADDR_W'(20'hFFFF8));
      // free with both neighbors free
      push_alloc(40);
      push_alloc(24);
      push_alloc(100);
      free_live_at(live_q.size() - 3);
      free_live_at(live_q.size() - 1);
      free_live_at(live_q.size() - 1);
      push_free(ADDR_W'(dead_q[dead_q.size() - 1]));
      // growth absorbing a free last block
      push_alloc(200);
      free_live_at(live_q.size() - 1);
      push_alloc(500);
      push_alloc(16);
      push_alloc(20'hFFFFF);

      // random traffic, bounded number of live blocks
      n = 0;
      while (n < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (live_q.size() >= MAX_LIVE && sel < 50) sel = 60;
         if (sel < 40) begin
            case ($urandom_range(0, 19))
               0: push_alloc(SIZE_W'($urandom_range(100000, 450000)));
               1: push_alloc(SIZE_W'($urandom_range(700000, 2097151)));
               2, 3, 4: push_alloc(SIZE_W'($urandom_range(257, 4096)));
               default: push_alloc(SIZE_W'($urandom_range(1, 256)));
            endcase
         end else if (sel < 50) begin
            push_alloc(SIZE_W'($urandom_range(0, 24)));
         end else if (sel < 88) begin
            if (live_q.size() > 0) free_live_at($urandom_range(0, live_q.size() - 1));
            else push_alloc(SIZE_W'($urandom_range(1, 64)));
         end else if (sel < 94) begin
            // double free only where the header still reads free
            if (dead_q.size() > 0) begin
               idx = $urandom_range(0, dead_q.size() - 1);
               if (!blk_alloc(dead_q[idx] - 8)) push_free(ADDR_W'(dead_q[idx]));
               else push_free(0);
            end else begin
               push_free(0);
            end
         end else begin
            // addresses that get rejected without touching the heap
            case ($urandom_range(0, 2))
               0: push_free(ADDR_W'($urandom | 1));
               1: push_free(ADDR_W'($urandom_range(0, 2) * 8));
               default: begin
                  a = epi_off + 8 + 8 * $urandom_range(0, 4000);
                  if (a < 64'h100000) push_free(ADDR_W'(a));
                  else push_free(ADDR_W'(20'hFFFF8));
               end
            endcase
         end
         n++;
      end

      // release everything so the heap ends coalesced
      while (live_q.size() > 0) free_live_at($urandom_range(0, live_q.size() - 1));
      stim_done = 1'b1;

      wait (op_q.size() == 0 && rsp_exp_q.size() == 0);
      repeat (50) @(posedge clock);
      if (!failed && rsp_exp_q.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // request driver, bursts with random gaps
   int burst_left;
   int gap_left;
   always @(posedge clock) begin
      heap_op_t cur;
      heap_rsp_t exp_rsp;
      bit take_next;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.func <= FUNC_ALLOC;
         req_chan.request_size <= '0;
         req_chan.block_addr <= '0;
         burst_left <= 4;
         gap_left <= 0;
      end else begin
         take_next = !req_chan.valid;
         if (req_chan.valid && req_chan.ready) begin
            cur = op_q.pop_front();
            exp_rsp.payload_addr = cur.exp_addr;
            exp_rsp.status = cur.exp_status;
            rsp_exp_q.push_back(exp_rsp);
            take_next = 1'b1;
         end
         if (take_next) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_chan.valid <= 1'b0;
            end else if (op_q.size() > 0) begin
               req_chan.valid <= 1'b1;
               req_chan.func <= op_q[0].func;
               req_chan.request_size <= op_q[0].request_size;
               req_chan.block_addr <= op_q[0].block_addr;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and backpressure
   int stall_mode;
   int mode_left;
   int hold_left;
   bit hold_done;
   always @(posedge clock) begin
      heap_rsp_t exp_rsp;
      bit rdy;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_mode <= 0;
         mode_left <= 100;
         hold_left <= 0;
         hold_done <= 1'b0;
         rsp_cnt <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_cnt <= rsp_cnt + 1;
            if (rsp_exp_q.size() == 0) begin
               $display("%0t: unexpected response addr=%h status=%0d", $time,
                        rsp_chan.payload_addr, rsp_chan.status);
               failed = 1'b1;
            end else begin
               exp_rsp = rsp_exp_q.pop_front();
               if (rsp_chan.payload_addr !== exp_rsp.payload_addr) begin
                  $display("%0t: payload_addr mismatch expected %h actual %h", $time,
                           exp_rsp.payload_addr, rsp_chan.payload_addr);
                  failed = 1'b1;
               end
               if (rsp_chan.status !== exp_rsp.status) begin
                  $display("%0t: status mismatch expected %0d actual %0d", $time,
                           exp_rsp.status, rsp_chan.status);
                  failed = 1'b1;
               end
            end
         end
         // one long hold-off while requests keep coming
         if (!hold_done && rsp_cnt == 150) begin
            hold_left <= 600;
            hold_done <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
         if (mode_left <= 1) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(20, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rdy = 1'b1;
            1: rdy = $urandom_range(0, 1);
            2: rdy = (cycle_cnt % 7) < 3;
            default: rdy = $urandom_range(0, 7) != 0;
         endcase
         rsp_chan.ready <= (hold_left > 0) ? 1'b0 : rdy;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial cycle_cnt = 0;

endmodule
